[sv/motor_can_frame_codec_core_macros.svh]
// Assertion helpers shared by the codec RTL.
`ifndef MOTOR_CAN_FRAME_CODEC_CORE_MACROS_SVH
`define MOTOR_CAN_FRAME_CODEC_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MCFC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcfc same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define MCFC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcfc next-cycle check failed");

`endif

[sv/mcfc_pkg.sv]
`timescale 1ns / 1ps
package mcfc_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int PARAM_BITS_DEF    = 12;

  localparam int QUOT_W      = 32;  // divider quotient / span width
  localparam int POS_FIELD_W = 16;
  localparam int PAR_FIELD_W = 12;
  localparam int NUM_LANES   = 5;   // pos, vel, trq, stiffness, damping
  localparam int Q_DEPTH     = 2;

  localparam int FB_POS_LSB = 40;
  localparam int FB_VEL_LSB = 28;
  localparam int FB_TRQ_LSB = 16;

  localparam logic [2:0] OP_ENABLE   = 3'd0;
  localparam logic [2:0] OP_DISABLE  = 3'd1;
  localparam logic [2:0] OP_ZERO     = 3'd2;
  localparam logic [2:0] OP_MIT      = 3'd3;
  localparam logic [2:0] OP_FEEDBACK = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RANGE   = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  localparam logic [2:0] REG_TX_ID   = 3'd0;
  localparam logic [2:0] REG_MST_ID  = 3'd1;
  localparam logic [2:0] REG_NIBBLE  = 3'd2;
  localparam logic [2:0] REG_POS_LIM = 3'd3;
  localparam logic [2:0] REG_VEL_LIM = 3'd4;
  localparam logic [2:0] REG_TRQ_LIM = 3'd5;
  localparam logic [2:0] REG_KP_LIM  = 3'd6;
  localparam logic [2:0] REG_KD_LIM  = 3'd7;

  localparam logic [30:0] POS_LIM_RST = 31'd819200;
  localparam logic [30:0] VEL_LIM_RST = 31'd1966080;
  localparam logic [30:0] TRQ_LIM_RST = 31'd655360;
  localparam logic [30:0] KP_LIM_RST  = 31'd32768000;
  localparam logic [30:0] KD_LIM_RST  = 31'd327680;

  localparam logic [7:0] FILL_BYTE    = 8'hFF;
  localparam logic [7:0] SPECIAL_BASE = 8'hFC;
  localparam logic [3:0] FRAME_LEN    = 4'd8;

  typedef enum logic [2:0] {
    K_SPECIAL = 3'd0,
    K_MIT     = 3'd1,
    K_FB      = 3'd2,
    K_BAD_CMD = 3'd3,
    K_BAD_FB  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [10:0] transmit_id;
    logic [10:0] fb_id;
    logic [3:0]  nibble;
    logic [30:0] pos_lim;
    logic [30:0] vel_lim;
    logic [30:0] trq_lim;
    logic [30:0] kp_lim;
    logic [30:0] kd_lim;
  } cfg_t;

  typedef struct packed {
    kind_t                       kind;
    logic [2:0]                  op;
    logic [NUM_LANES-1:0][31:0]  cmd;
    logic [63:0]                 rx_data;
    logic [31:0]                 rx_time;
  } item_t;

  typedef struct packed {
    logic valid;
  } qctl_t;

  function automatic logic sym_ok(input logic [31:0] v, input logic [30:0] lim);
    logic signed [32:0] vs;
    logic signed [32:0] ls;
    vs = $signed({v[31], v});
    ls = $signed({2'b00, lim});
    return (vs >= -ls) && (vs <= ls);
  endfunction

  function automatic logic pos_ok(input logic [31:0] v, input logic [30:0] lim);
    return !v[31] && (v[30:0] <= lim);
  endfunction

endpackage

[sv/mcfc_ifs.sv]
`timescale 1ns / 1ps
interface mcfc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic signed [31:0] command_position;
  logic signed [31:0] command_velocity;
  logic signed [31:0] command_torque;
  logic signed [31:0] command_stiffness;
  logic signed [31:0] command_damping;
  logic [10:0] rx_identifier;
  logic [3:0]  rx_length;
  logic [63:0] rx_payload;
  logic [31:0] rx_time;
  modport source (output valid, op, command_position, command_velocity, command_torque,
                  command_stiffness, command_damping, rx_identifier, rx_length,
                  rx_payload, rx_time, input ready);
  modport sink (input valid, op, command_position, command_velocity, command_torque,
                command_stiffness, command_damping, rx_identifier, rx_length,
                rx_payload, rx_time, output ready);
endinterface

interface mcfc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [10:0] frame_identifier;
  logic [63:0] frame_payload;
  logic signed [31:0] feedback_position;
  logic signed [31:0] feedback_velocity;
  logic signed [31:0] feedback_torque;
  logic [3:0]  feedback_fault;
  logic [7:0]  driver_temperature;
  logic [7:0]  rotor_temperature;
  logic [31:0] feedback_time;
  logic [31:0] feedback_count;
  logic        has_feedback;
  modport source (output valid, status, frame_identifier, frame_payload, feedback_position,
                  feedback_velocity, feedback_torque, feedback_fault, driver_temperature,
                  rotor_temperature, feedback_time, feedback_count, has_feedback,
                  input ready);
  modport sink (input valid, status, frame_identifier, frame_payload, feedback_position,
                feedback_velocity, feedback_torque, feedback_fault, driver_temperature,
                rotor_temperature, feedback_time, feedback_count, has_feedback,
                output ready);
endinterface

interface mcfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  idx;
  logic [31:0] wdata;
  modport source (output valid, idx, wdata, input ready);
  modport sink (input valid, idx, wdata, output ready);
endinterface

[sv/mcfc_front.sv]
`timescale 1ns / 1ps
module mcfc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  mcfc_pkg::cfg_t     cfg,
  mcfc_in_if.sink            in_ch,
  output mcfc_pkg::qctl_t    qctl,
  input  logic               q_pop,
  output mcfc_pkg::item_t    q_item
);
  localparam int QD  = mcfc_pkg::Q_DEPTH;
  localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);

  mcfc_pkg::item_t  mem [QD];
  mcfc_pkg::item_t  item;
  mcfc_pkg::kind_t  kind;
  logic [QAW-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             push, mit_ok, fb_ok;

  assign mit_ok = mcfc_pkg::sym_ok(in_ch.command_position, cfg.pos_lim) &&
                  mcfc_pkg::sym_ok(in_ch.command_velocity, cfg.vel_lim) &&
                  mcfc_pkg::sym_ok(in_ch.command_torque, cfg.trq_lim) &&
                  mcfc_pkg::pos_ok(in_ch.command_stiffness, cfg.kp_lim) &&
                  mcfc_pkg::pos_ok(in_ch.command_damping, cfg.kd_lim);
  assign fb_ok = (in_ch.rx_length == mcfc_pkg::FRAME_LEN) &&
                 (in_ch.rx_identifier == cfg.fb_id) &&
                 (in_ch.rx_payload[59:56] == cfg.nibble);

  always_comb begin
    case (in_ch.op) inside
      [mcfc_pkg::OP_ENABLE:mcfc_pkg::OP_ZERO]: kind = mcfc_pkg::K_SPECIAL;
      mcfc_pkg::OP_MIT:      kind = mit_ok ? mcfc_pkg::K_MIT : mcfc_pkg::K_BAD_CMD;
      mcfc_pkg::OP_FEEDBACK: kind = fb_ok ? mcfc_pkg::K_FB : mcfc_pkg::K_BAD_FB;
      default:               kind = mcfc_pkg::K_BAD_CMD;
    endcase
  end

  always_comb begin
    item.kind    = kind;
    item.op      = in_ch.op;
    item.cmd[0]  = in_ch.command_position;
    item.cmd[1]  = in_ch.command_velocity;
    item.cmd[2]  = in_ch.command_torque;
    item.cmd[3]  = in_ch.command_stiffness;
    item.cmd[4]  = in_ch.command_damping;
    item.rx_data = in_ch.rx_payload;
    item.rx_time = in_ch.rx_time;
  end

  assign in_ch.ready = (cnt_r != QCW'(QD));
  assign push        = in_ch.valid && in_ch.ready;
  assign qctl.valid  = (cnt_r != '0);
  assign q_item      = mem[rptr_r];

  always_comb begin
    wptr_nxt = push ? QAW'((32'(wptr_r) + 1) % QD) : wptr_r;
    rptr_nxt = q_pop ? QAW'((32'(rptr_r) + 1) % QD) : rptr_r;
    cnt_nxt  = cnt_r + QCW'(push) - QCW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end
endmodule

[sv/mcfc_div.sv]
`timescale 1ns / 1ps
module mcfc_div #(
  parameter int PW = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [PW-1:0]               dividend,
  input  logic [mcfc_pkg::QUOT_W-1:0] divisor,
  output logic                        busy,
  output logic [mcfc_pkg::QUOT_W-1:0] quotient
);
  localparam int QW  = mcfc_pkg::QUOT_W;
  localparam int CW  = $clog2(QW + 1);

  logic [QW-1:0] rem_r, rem_nxt, sh_r, sh_nxt, dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [QW+1:0] diff;
  logic          ge;

  // restoring step: high part of dividend seeds the remainder (always below divisor)
  assign diff = {1'b0, rem_r, sh_r[QW-1]} - {2'b00, dvs_r};
  assign ge   = !diff[QW+1];

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = QW'(dividend[PW-1:QW]);
      sh_nxt   = dividend[QW-1:0];
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[QW-1:0] : {rem_r[QW-2:0], sh_r[QW-1]};
      sh_nxt   = {sh_r[QW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = sh_r;
endmodule

[sv/mcfc_back.sv]
`timescale 1ns / 1ps
module mcfc_back #(
  parameter int POSITION_BITS = mcfc_pkg::POSITION_BITS_DEF,
  parameter int PARAM_BITS    = mcfc_pkg::PARAM_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mcfc_pkg::cfg_t  cfg,
  input  mcfc_pkg::qctl_t qctl,
  input  mcfc_pkg::item_t q_item,
  output logic            q_pop,
  mcfc_out_if.source      out_ch
);
  localparam int QW   = mcfc_pkg::QUOT_W;
  localparam int NL   = mcfc_pkg::NUM_LANES;
  localparam int MAXB = (POSITION_BITS > PARAM_BITS) ? POSITION_BITS : PARAM_BITS;
  localparam int PW   = QW + MAXB;
  localparam int PFW  = mcfc_pkg::POS_FIELD_W;
  localparam int AFW  = mcfc_pkg::PAR_FIELD_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PREP = 3'b010,
    S_RUN  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  mcfc_pkg::item_t      item_r;
  logic                 load_item, start, out_free;
  logic [NL-1:0]        busy;
  logic [NL-1:0][QW-1:0]   quo, qz, span;
  logic [NL-1:0][30:0]     lim;
  logic [63:0]          special_frame, mit_frame;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [10:0] fid_r, fid_nxt;
  logic [63:0] pay_r, pay_nxt;
  logic [31:0] pos_r, pos_nxt, vel_r, vel_nxt, trq_r, trq_nxt;
  logic [3:0]  fault_r, fault_nxt;
  logic [7:0]  drv_r, drv_nxt, rot_r, rot_nxt;
  logic [31:0] time_r, time_nxt, count_r, count_nxt;

  assign lim[0] = cfg.pos_lim;
  assign lim[1] = cfg.vel_lim;
  assign lim[2] = cfg.trq_lim;
  assign lim[3] = cfg.kp_lim;
  assign lim[4] = cfg.kd_lim;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    localparam int LB  = (g == 0) ? POSITION_BITS : PARAM_BITS;
    localparam int FW  = (g == 0) ? PFW : AFW;
    localparam int FLO = (g == 0) ? mcfc_pkg::FB_POS_LSB :
                         (g == 1) ? mcfc_pkg::FB_VEL_LSB : mcfc_pkg::FB_TRQ_LSB;
    logic signed [32:0] sum;
    logic [QW-1:0]      off;
    logic [LB-1:0]      scale;
    logic [FW-1:0]      code_raw;
    logic [LB-1:0]      code_c;
    logic [QW+LB-1:0]   prod, quant;
    logic [PW-1:0]      dvd;
    logic [QW-1:0]      dvs;

    // symmetric lanes span 2*lim, gain lanes span lim
    assign span[g]  = (g < 3) ? {lim[g], 1'b0} : {1'b0, lim[g]};
    assign sum      = $signed({item_r.cmd[g][31], item_r.cmd[g]}) + $signed({2'b00, lim[g]});
    assign off      = (g < 3) ? sum[QW-1:0] : item_r.cmd[g];
    assign scale    = {LB{1'b1}};
    assign code_raw = item_r.rx_data[FLO +: FW];
    assign code_c   = (code_raw > FW'(scale)) ? scale : code_raw[LB-1:0];
    assign prod     = {{QW{1'b0}}, code_c} * {{LB{1'b0}}, span[g]};
    assign quant    = {off, {LB{1'b0}}} - {{LB{1'b0}}, off};  // off * (2^LB - 1)
    assign dvd      = (item_r.kind == mcfc_pkg::K_FB) ? PW'(prod) : PW'(quant);
    assign dvs      = (item_r.kind == mcfc_pkg::K_FB) ? QW'(scale) : span[g];
    assign qz[g]    = (span[g] == '0) ? '0 : quo[g];

    mcfc_div #(.PW(PW)) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (start),
      .dividend (dvd),
      .divisor  (dvs),
      .busy     (busy[g]),
      .quotient (quo[g])
    );
  end

  assign special_frame = {{7{mcfc_pkg::FILL_BYTE}},
                          mcfc_pkg::SPECIAL_BASE + {6'd0, q_item.op[1:0]}};
  assign mit_frame = {PFW'(qz[0][POSITION_BITS-1:0]), AFW'(qz[1][PARAM_BITS-1:0]),
                      AFW'(qz[3][PARAM_BITS-1:0]), AFW'(qz[4][PARAM_BITS-1:0]),
                      AFW'(qz[2][PARAM_BITS-1:0])};
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    load_item     = 1'b0;
    start         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    fid_nxt       = fid_r;
    pay_nxt       = pay_r;
    pos_nxt       = pos_r;
    vel_nxt       = vel_r;
    trq_nxt       = trq_r;
    fault_nxt     = fault_r;
    drv_nxt       = drv_r;
    rot_nxt       = rot_r;
    time_nxt      = time_r;
    count_nxt     = count_r;
    case (state_r)
      S_IDLE: begin
        if (qctl.valid && out_free) begin
          q_pop = 1'b1;
          case (q_item.kind)
            mcfc_pkg::K_MIT, mcfc_pkg::K_FB: begin
              load_item = 1'b1;
              state_nxt = S_PREP;
            end
            mcfc_pkg::K_SPECIAL: begin
              out_valid_nxt = 1'b1;
              status_nxt    = mcfc_pkg::STAT_OK;
              fid_nxt       = cfg.transmit_id;
              pay_nxt       = special_frame;
            end
            mcfc_pkg::K_BAD_FB: begin
              out_valid_nxt = 1'b1;
              status_nxt    = mcfc_pkg::STAT_IGNORED;
              fid_nxt       = '0;
              pay_nxt       = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              status_nxt    = mcfc_pkg::STAT_RANGE;
              fid_nxt       = '0;
              pay_nxt       = '0;
            end
          endcase
        end
      end
      S_PREP: begin
        start     = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (busy == '0) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = mcfc_pkg::STAT_OK;
          if (item_r.kind == mcfc_pkg::K_FB) begin
            fid_nxt   = '0;
            pay_nxt   = '0;
            pos_nxt   = quo[0] - {1'b0, lim[0]};
            vel_nxt   = quo[1] - {1'b0, lim[1]};
            trq_nxt   = quo[2] - {1'b0, lim[2]};
            fault_nxt = item_r.rx_data[63:60];
            drv_nxt   = item_r.rx_data[15:8];
            rot_nxt   = item_r.rx_data[7:0];
            time_nxt  = item_r.rx_time;
            count_nxt = count_r + 32'd1;
          end else begin
            fid_nxt = cfg.transmit_id;
            pay_nxt = mit_frame;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      item_r <= q_item;
    end
    status_r <= status_nxt;
    fid_r    <= fid_nxt;
    pay_r    <= pay_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      vel_r       <= '0;
      trq_r       <= '0;
      fault_r     <= '0;
      drv_r       <= '0;
      rot_r       <= '0;
      time_r      <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      vel_r       <= vel_nxt;
      trq_r       <= trq_nxt;
      fault_r     <= fault_nxt;
      drv_r       <= drv_nxt;
      rot_r       <= rot_nxt;
      time_r      <= time_nxt;
      count_r     <= count_nxt;
    end
  end

  // stored feedback only changes while the result slot is empty
  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = status_r;
  assign out_ch.frame_identifier   = fid_r;
  assign out_ch.frame_payload      = pay_r;
  assign out_ch.feedback_position  = pos_r;
  assign out_ch.feedback_velocity  = vel_r;
  assign out_ch.feedback_torque    = trq_r;
  assign out_ch.feedback_fault     = fault_r;
  assign out_ch.driver_temperature = drv_r;
  assign out_ch.rotor_temperature  = rot_r;
  assign out_ch.feedback_time      = time_r;
  assign out_ch.feedback_count     = count_r;
  assign out_ch.has_feedback       = (count_r != '0);
endmodule

[sv/motor_can_frame_codec_core.sv]
// Special frames and rejected items go from the queue straight to the output register;
// MIT command and accepted feedback items first run the five 32-step restoring dividers
// in parallel, one per field. Throughput: one simple item per cycle while the output
// is accepted; an MIT/feedback item holds the back end until its dividers finish, and a
// 2-entry queue takes new items meanwhile. Reset (rst_n low, synchronous) restores the
// default limits, zeroes ids and stored feedback, and empties the queue.
`timescale 1ns / 1ps
`include "motor_can_frame_codec_core_macros.svh"
module motor_can_frame_codec_core #(
  parameter int POSITION_BITS = mcfc_pkg::POSITION_BITS_DEF,
  parameter int PARAM_BITS    = mcfc_pkg::PARAM_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mcfc_in_if.sink    in_ch,
  mcfc_out_if.source out_ch,
  mcfc_cfg_if.sink   cfg_ch
);
  mcfc_pkg::cfg_t  cfg_r, cfg_nxt;
  mcfc_pkg::qctl_t qctl;
  mcfc_pkg::item_t q_item;
  logic            q_pop;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        mcfc_pkg::REG_TX_ID:   cfg_nxt.transmit_id = cfg_ch.wdata[10:0];
        mcfc_pkg::REG_MST_ID:  cfg_nxt.fb_id       = cfg_ch.wdata[10:0];
        mcfc_pkg::REG_NIBBLE:  cfg_nxt.nibble      = cfg_ch.wdata[3:0];
        mcfc_pkg::REG_POS_LIM: cfg_nxt.pos_lim     = cfg_ch.wdata[30:0];
        mcfc_pkg::REG_VEL_LIM: cfg_nxt.vel_lim     = cfg_ch.wdata[30:0];
        mcfc_pkg::REG_TRQ_LIM: cfg_nxt.trq_lim     = cfg_ch.wdata[30:0];
        mcfc_pkg::REG_KP_LIM:  cfg_nxt.kp_lim      = cfg_ch.wdata[30:0];
        mcfc_pkg::REG_KD_LIM:  cfg_nxt.kd_lim      = cfg_ch.wdata[30:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.transmit_id <= '0;
      cfg_r.fb_id       <= '0;
      cfg_r.nibble      <= '0;
      cfg_r.pos_lim     <= mcfc_pkg::POS_LIM_RST;
      cfg_r.vel_lim     <= mcfc_pkg::VEL_LIM_RST;
      cfg_r.trq_lim     <= mcfc_pkg::TRQ_LIM_RST;
      cfg_r.kp_lim      <= mcfc_pkg::KP_LIM_RST;
      cfg_r.kd_lim      <= mcfc_pkg::KD_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mcfc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .qctl   (qctl),
    .q_pop  (q_pop),
    .q_item (q_item)
  );

  mcfc_back #(
    .POSITION_BITS (POSITION_BITS),
    .PARAM_BITS    (PARAM_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .qctl   (qctl),
    .q_item (q_item),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  `MCFC_ASSERT_IMP(a_pop_needs_item, q_pop, qctl.valid)
  `MCFC_ASSERT_IMP(a_reject_no_frame, out_ch.valid && out_ch.status != mcfc_pkg::STAT_OK, out_ch.frame_payload == 64'd0 && out_ch.frame_identifier == 11'd0)
  `MCFC_ASSERT_IMP(a_fb_flag, out_ch.valid, out_ch.has_feedback == (out_ch.feedback_count != 32'd0))
  `MCFC_ASSERT_NXT(a_ignored_keeps_count, out_ch.valid && out_ch.ready && out_ch.status == mcfc_pkg::STAT_IGNORED, $stable(out_ch.feedback_count))
endmodule
